FILE: hw/rtl/pal_pkg.sv
`default_nettype none

package pal_pkg;

    // Operation codes carried by func
    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_GET    = 2'd1,
        FUNC_DELETE = 2'd2,
        FUNC_CLEAR  = 2'd3
    } func_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    localparam logic [6:0] CAP_RESET = 7'd64;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_CHK,
        S_INS_RD,
        S_INS_WR,
        S_INS_PUT,
        S_GET_RD,
        S_GET_CAP,
        S_DEL_RD,
        S_DEL_CAP,
        S_DEL_CHK,
        S_DEL_MRD,
        S_DEL_MWR,
        S_DONE
    } state_t;

    // Memory read address source
    typedef enum logic {
        RD_PTR,
        RD_PTR_M1
    } rd_sel_t;

    // Memory write address and data source
    typedef enum logic [1:0] {
        WR_UP,
        WR_DOWN,
        WR_NEW
    } wr_sel_t;

    typedef struct packed {
        logic    load;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    ptr_inc;
        logic    ptr_dec;
        logic    cap_rv;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    publish;
    } cmd_t;

    typedef struct packed {
        func_t op;
        logic  in_err;
        logic  at_tgt;
        logic  at_end;
        logic  out_free;
    } sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/pal_ctrl.sv
`default_nettype none

module pal_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire pal_pkg::sts_t sts,
    output pal_pkg::cmd_t      cmd
);

    pal_pkg::state_t state_reg;
    pal_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pal_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            pal_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (sts.in_err || sts.op == pal_pkg::FUNC_CLEAR)
                    begin
                        state_next = pal_pkg::S_DONE;
                    end
                    else if (sts.op == pal_pkg::FUNC_INSERT)
                    begin
                        state_next = pal_pkg::S_INS_CHK;
                    end
                    else if (sts.op == pal_pkg::FUNC_GET)
                    begin
                        state_next = pal_pkg::S_GET_RD;
                    end
                    else
                    begin
                        state_next = pal_pkg::S_DEL_RD;
                    end
                end
            end
            pal_pkg::S_INS_CHK:
            begin
                state_next = sts.at_tgt ? pal_pkg::S_INS_PUT : pal_pkg::S_INS_RD;
            end
            pal_pkg::S_INS_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = pal_pkg::RD_PTR_M1;
                state_next = pal_pkg::S_INS_WR;
            end
            pal_pkg::S_INS_WR:
            begin
                // move the entry below ptr up by one slot
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = pal_pkg::WR_UP;
                cmd.ptr_dec = 1'b1;
                state_next  = pal_pkg::S_INS_CHK;
            end
            pal_pkg::S_INS_PUT:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = pal_pkg::WR_NEW;
                cmd.cnt_inc = 1'b1;
                state_next  = pal_pkg::S_DONE;
            end
            pal_pkg::S_GET_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = pal_pkg::RD_PTR;
                state_next = pal_pkg::S_GET_CAP;
            end
            pal_pkg::S_GET_CAP:
            begin
                cmd.cap_rv = 1'b1;
                state_next = pal_pkg::S_DONE;
            end
            pal_pkg::S_DEL_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = pal_pkg::RD_PTR;
                state_next = pal_pkg::S_DEL_CAP;
            end
            pal_pkg::S_DEL_CAP:
            begin
                cmd.cap_rv  = 1'b1;
                cmd.ptr_inc = 1'b1;
                state_next  = pal_pkg::S_DEL_CHK;
            end
            pal_pkg::S_DEL_CHK:
            begin
                if (sts.at_end)
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = pal_pkg::S_DONE;
                end
                else
                begin
                    state_next = pal_pkg::S_DEL_MRD;
                end
            end
            pal_pkg::S_DEL_MRD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = pal_pkg::RD_PTR;
                state_next = pal_pkg::S_DEL_MWR;
            end
            pal_pkg::S_DEL_MWR:
            begin
                // move the entry at ptr down by one slot
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = pal_pkg::WR_DOWN;
                cmd.ptr_inc = 1'b1;
                state_next  = pal_pkg::S_DEL_CHK;
            end
            pal_pkg::S_DONE:
            begin
                // hold the result until the output register is free
                if (sts.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = pal_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pal_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/pal_datapath.sv
`default_nettype none

module pal_datapath #(
    parameter int DEPTH = 64
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [1:0]    func,
    input  wire logic [5:0]    pos,
    input  wire logic [31:0]   new_value,
    input  wire logic          cfg_valid,
    input  wire logic [6:0]    cfg_data,
    input  wire logic          out_ready,
    output logic               out_valid,
    output logic [1:0]         status,
    output logic [31:0]        read_value,
    output logic [6:0]         count_now,
    input  wire pal_pkg::cmd_t cmd,
    output pal_pkg::sts_t      sts
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int MW = (CW > 7) ? CW : 7;

    logic [31:0]       mem [DEPTH];
    logic [31:0]       rdata_reg;

    logic [6:0]        cap_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     ptr_reg;
    logic [CW-1:0]     tgt_reg;
    logic [31:0]       word_reg;
    logic [31:0]       rv_reg;
    pal_pkg::status_t  st_reg;

    logic              out_valid_reg;
    logic [1:0]        status_reg;
    logic [31:0]       read_value_reg;
    logic [6:0]        count_now_reg;

    pal_pkg::func_t    op;
    logic [MW-1:0]     pos_w;
    logic [MW-1:0]     cnt_w;
    logic [MW-1:0]     cap_w;
    logic [MW-1:0]     depth_w;
    logic [MW-1:0]     cap_eff;
    logic              full;
    logic              out_of_range;
    logic [CW-1:0]     ptr_m1;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic [31:0]       wr_data;

    assign op           = pal_pkg::func_t'(func);
    assign pos_w        = MW'(pos);
    assign cnt_w        = MW'(count_reg);
    assign cap_w        = MW'(cap_reg);
    assign depth_w      = MW'(DEPTH);
    assign cap_eff      = (cap_w > depth_w) ? depth_w : cap_w;
    assign full         = (cnt_w >= cap_eff);
    assign out_of_range = (pos_w >= cnt_w);
    assign ptr_m1       = ptr_reg - CW'(1);

    always_comb
    begin
        sts.op       = op;
        sts.at_tgt   = (ptr_reg == tgt_reg);
        sts.at_end   = (ptr_reg == count_reg);
        sts.out_free = !out_valid_reg || out_ready;
        case (op) inside
            pal_pkg::FUNC_INSERT: sts.in_err = full;
            pal_pkg::FUNC_GET,
            pal_pkg::FUNC_DELETE: sts.in_err = out_of_range;
            default:              sts.in_err = 1'b0;
        endcase
    end

    assign rd_addr = (cmd.rd_sel == pal_pkg::RD_PTR_M1) ? AW'(ptr_m1) : AW'(ptr_reg);

    always_comb
    begin
        case (cmd.wr_sel)
            pal_pkg::WR_UP:
            begin
                wr_addr = AW'(ptr_reg);
                wr_data = rdata_reg;
            end
            pal_pkg::WR_DOWN:
            begin
                wr_addr = AW'(ptr_m1);
                wr_data = rdata_reg;
            end
            default:
            begin
                wr_addr = AW'(tgt_reg);
                wr_data = word_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Operation registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            word_reg <= new_value;
            rv_reg   <= '0;
            if (op == pal_pkg::FUNC_INSERT)
            begin
                ptr_reg <= count_reg;
                tgt_reg <= (pos_w > cnt_w) ? count_reg : CW'(pos_w);
            end
            else
            begin
                ptr_reg <= CW'(pos_w);
                tgt_reg <= CW'(pos_w);
            end
            if (op == pal_pkg::FUNC_INSERT && full)
            begin
                st_reg <= pal_pkg::ST_FULL;
            end
            else if ((op == pal_pkg::FUNC_GET || op == pal_pkg::FUNC_DELETE) && out_of_range)
            begin
                st_reg <= pal_pkg::ST_RANGE;
            end
            else
            begin
                st_reg <= pal_pkg::ST_OK;
            end
        end
        else
        begin
            if (cmd.ptr_inc)
            begin
                ptr_reg <= ptr_reg + CW'(1);
            end
            else if (cmd.ptr_dec)
            begin
                ptr_reg <= ptr_m1;
            end
            if (cmd.cap_rv)
            begin
                rv_reg <= rdata_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= pal_pkg::CAP_RESET;
            count_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                cap_reg <= cfg_data;
            end
            if (cmd.load && op == pal_pkg::FUNC_CLEAR)
            begin
                count_reg <= '0;
            end
            else if (cmd.cnt_inc)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd.cnt_dec)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.publish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            status_reg     <= st_reg;
            read_value_reg <= rv_reg;
            count_now_reg  <= 7'(count_reg);
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign read_value = read_value_reg;
    assign count_now  = count_now_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/positional_array_list.sv
// Ordered list of 32-bit words held in positions 0 to count-1 of a DEPTH-word RAM.
// Input channel (in_valid/in_ready) carries one request: func, pos, new_value.
// Output channel (out_valid/out_ready) returns one result per request:
// status, read_value and count_now.
// Config channel (cfg_valid/cfg_ready, cfg_data) sets the capacity in use;
// cfg_ready is always high. Write it only while no request is in flight.
// One request is worked on at a time; in_ready is high only when the
// controller is idle. States from accept to the result register:
//   clear, full list, out of range:  DONE
//   get:     GET_RD, GET_CAP, DONE
//   insert:  INS_CHK; per move INS_RD, INS_WR, INS_CHK; INS_PUT, DONE
//   delete:  DEL_RD, DEL_CAP, DEL_CHK; per move DEL_MRD, DEL_MWR, DEL_CHK; DONE
// Every moved entry costs a RAM read, a write and a check on the single
// read port and single write port of the list RAM.
// A new request is taken the cycle after the result is registered, even if the
// receiver has not yet taken the result; when a second result is ready and the
// output register still holds the first, the block waits for out_ready.
// Reset empties the list (count 0), sets the capacity to 64 and clears
// out_valid; RAM contents are not cleared.
`default_nettype none

module positional_array_list #(
    parameter int DEPTH = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  func,
    input  wire logic [5:0]  pos,
    input  wire logic [31:0] new_value,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [31:0]      read_value,
    output logic [6:0]       count_now,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [6:0]  cfg_data
);

    pal_pkg::cmd_t cmd;
    pal_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    pal_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pal_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .func       (func),
        .pos        (pos),
        .new_value  (new_value),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .status     (status),
        .read_value (read_value),
        .count_now  (count_now),
        .cmd        (cmd),
        .sts        (sts)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/pal_checker.sv
`default_nettype none

module pal_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [1:0]  status,
    input wire logic [31:0] read_value,
    input wire logic [6:0]  count_now
);

    // One request at a time: taking a request closes the input
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while another is in flight");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == pal_pkg::ST_OK || status == pal_pkg::ST_RANGE
                       || status == pal_pkg::ST_FULL))
        else $error("undefined status code");

    a_err_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != pal_pkg::ST_OK |-> read_value == 32'd0)
        else $error("failed request returned data");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
                                    && $stable(read_value) && $stable(count_now))
        else $error("stalled result dropped or changed");

endmodule

bind positional_array_list pal_checker u_pal_checker (.*);

`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int LIST_DEPTH  = 64;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int SETTLE      = 200;
    localparam int NO_CFG      = -1;

    typedef struct packed {
        pal_pkg::status_t status;
        logic [31:0]      word;
        logic [6:0]       count;
    } list_result_t;

    typedef struct {
        int             cfg_value;
        pal_pkg::func_t op;
        logic [5:0]     p;
        logic [31:0]    w;
        bit             typed;
        list_result_t   want;
    } stim_row_t;

    typedef enum {
        MIX_GROW,
        MIX_SHRINK,
        MIX_EVEN
    } op_mix_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  func;
    logic [5:0]  pos;
    logic [31:0] new_value;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [31:0] read_value;
    logic [6:0]  count_now;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [6:0]  cfg_data;

    // Shadow copy of the list
    logic [31:0] shadow_words [LIST_DEPTH];
    int unsigned shadow_count;
    logic [6:0]  shadow_cap;

    list_result_t pending_results [$];
    stim_row_t    directed_rows [$];

    int  n_sent;
    int  n_results;
    int  n_cfg;
    int  n_full;
    int  n_range;
    int  n_errors;
    int  cycle_count;
    bit  calm;

    positional_array_list #(
        .DEPTH(LIST_DEPTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .pos       (pos),
        .new_value (new_value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .read_value(read_value),
        .count_now (count_now),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int draw_gap();
        if (calm)
            return 0;
        return $urandom_range(0, 15);
    endfunction

    function automatic list_result_t predict_list_op(input pal_pkg::func_t op,
                                                     input logic [5:0] p,
                                                     input logic [31:0] w);
        list_result_t r;
        int unsigned  cap;
        int unsigned  at;
        r.status = pal_pkg::ST_OK;
        r.word   = '0;
        cap = (shadow_cap > LIST_DEPTH) ? LIST_DEPTH : shadow_cap;
        case (op)
            pal_pkg::FUNC_INSERT:
            begin
                if (shadow_count >= cap)
                begin
                    r.status = pal_pkg::ST_FULL;
                end
                else
                begin
                    at = (p > shadow_count) ? shadow_count : p;
                    for (int i = shadow_count; i > at; i--)
                        shadow_words[i] = shadow_words[i - 1];
                    shadow_words[at] = w;
                    shadow_count++;
                end
            end
            pal_pkg::FUNC_GET:
            begin
                if (p >= shadow_count)
                    r.status = pal_pkg::ST_RANGE;
                else
                    r.word = shadow_words[p];
            end
            pal_pkg::FUNC_DELETE:
            begin
                if (p >= shadow_count)
                begin
                    r.status = pal_pkg::ST_RANGE;
                end
                else
                begin
                    r.word = shadow_words[p];
                    for (int i = p + 1; i < shadow_count; i++)
                        shadow_words[i - 1] = shadow_words[i];
                    shadow_count--;
                end
            end
            default:
            begin
                shadow_count = 0;
            end
        endcase
        r.count = shadow_count[6:0];
        if (r.status == pal_pkg::ST_FULL)
            n_full++;
        if (r.status == pal_pkg::ST_RANGE)
            n_range++;
        return r;
    endfunction

    function automatic stim_row_t make_row(input int cfg_value, input pal_pkg::func_t op,
                                           input logic [5:0] p, input logic [31:0] w,
                                           input bit typed, input pal_pkg::status_t st,
                                           input logic [31:0] rd, input logic [6:0] cnt);
        stim_row_t row;
        row.cfg_value   = cfg_value;
        row.op          = op;
        row.p           = p;
        row.w           = w;
        row.typed       = typed;
        row.want.status = st;
        row.want.word   = rd;
        row.want.count  = cnt;
        return row;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH at result %0d, %s: got %h, want %h",
                 n_results, what, got, want);
        n_errors++;
    endtask

    // Hold the request until accepted, then record what it must return
    task automatic send_request(input pal_pkg::func_t op, input logic [5:0] p,
                                input logic [31:0] w, input bit typed,
                                input list_result_t want);
        int           gap;
        list_result_t predicted;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        func      <= op;
        pos       <= p;
        new_value <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = predict_list_op(op, p, w);
        pending_results.push_back(typed ? want : predicted);
        n_sent++;
    endtask

    // Drain every outstanding result before touching the register
    task automatic write_capacity(input logic [6:0] cap);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid  <= 1'b0;
        shadow_cap = cap;
        n_cfg++;
    endtask

    task automatic run_random_phase(input int n_items, input op_mix_t mix);
        int             roll;
        int             ins_cut;
        int             get_cut;
        int             del_cut;
        pal_pkg::func_t op;
        logic [5:0]     p;
        list_result_t   blank;
        blank = '0;
        case (mix)
            MIX_GROW:
            begin
                ins_cut = 65; get_cut = 80; del_cut = 97;
            end
            MIX_SHRINK:
            begin
                ins_cut = 20; get_cut = 35; del_cut = 97;
            end
            default:
            begin
                ins_cut = 40; get_cut = 65; del_cut = 97;
            end
        endcase
        for (int k = 0; k < n_items; k++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < ins_cut)
                op = pal_pkg::FUNC_INSERT;
            else if (roll < get_cut)
                op = pal_pkg::FUNC_GET;
            else if (roll < del_cut)
                op = pal_pkg::FUNC_DELETE;
            else
                op = pal_pkg::FUNC_CLEAR;
            // Mostly positions that land inside the list, the rest anywhere
            if ($urandom_range(0, 4) == 0)
                p = 6'($urandom_range(0, 63));
            else if (op == pal_pkg::FUNC_INSERT)
                p = (shadow_count > 63) ? 6'd63 : 6'($urandom_range(0, shadow_count));
            else if (shadow_count > 0)
                p = 6'($urandom_range(0, shadow_count - 1));
            else
                p = 6'($urandom_range(0, 63));
            send_request(op, p, $urandom, 1'b0, blank);
        end
    endtask

    // Receiver side: stall at random, then check each result in order
    initial
    begin
        list_result_t exp;
        int           gap;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = draw_gap();
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            n_results++;
            if (pending_results.size() == 0)
            begin
                report_mismatch("result with nothing outstanding", read_value, 32'h0);
            end
            else
            begin
                exp = pending_results.pop_front();
                if (status !== exp.status)
                    report_mismatch("status", 32'(status), 32'(exp.status));
                if (read_value !== exp.word)
                    report_mismatch("read_value", read_value, exp.word);
                if (count_now !== exp.count)
                    report_mismatch("count_now", 32'(count_now), 32'(exp.count));
            end
        end
    end

    initial
    begin
        stim_row_t    row;
        list_result_t blank;
        op_mix_t      mix;
        int           pick;
        blank       = '0;
        n_sent      = 0;
        n_results   = 0;
        n_cfg       = 0;
        n_full      = 0;
        n_range     = 0;
        n_errors    = 0;
        cycle_count = 0;
        calm        = 1'b0;
        for (int i = 0; i < LIST_DEPTH; i++)
            shadow_words[i] = '0;
        shadow_count = 0;
        shadow_cap   = pal_pkg::CAP_RESET;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        func      <= pal_pkg::FUNC_INSERT;
        pos       <= '0;
        new_value <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty list, bounds, clamp past end, full list, zero and oversize capacity
        directed_rows.push_back(make_row(NO_CFG, pal_pkg::FUNC_GET, 6'd0, 32'h0, 1'b1,
                                         pal_pkg::ST_RANGE, 32'h0, 7'd0));
        directed_rows.push_back(make_row(NO_CFG, pal_pkg::FUNC_DELETE, 6'd63, 32'h0, 1'b1,
                                         pal_pkg::ST_RANGE, 32'h0, 7'd0));
        directed_rows.push_back(make_row(NO_CFG, pal_pkg::FUNC_INSERT, 6'd63, 32'hFFFF_FFFF,
                                         1'b1, pal_pkg::ST_OK, 32'h0, 7'd1));
        directed_rows.push_back(make_row(NO_CFG, pal_pkg::FUNC_INSERT, 6'd0, 32'h0, 1'b1,
                                         pal_pkg::ST_OK, 32'h0, 7'd2));
        directed_rows.push_back(make_row(NO_CFG, pal_pkg::FUNC_GET, 6'd0, 32'h0, 1'b1,
                                         pal_pkg::ST_OK, 32'h0, 7'd2));
        directed_rows.push_back(make_row(NO_CFG, pal_pkg::FUNC_GET, 6'd1, 32'h0, 1'b1,
                                         pal_pkg::ST_OK, 32'hFFFF_FFFF, 7'd2));
        directed_rows.push_back(make_row(NO_CFG, pal_pkg::FUNC_GET, 6'd2, 32'h0, 1'b1,
                                         pal_pkg::ST_RANGE, 32'h0, 7'd2));
        directed_rows.push_back(make_row(NO_CFG, pal_pkg::FUNC_INSERT, 6'd1, 32'hA5A5_A5A5,
                                         1'b0, pal_pkg::ST_OK, 32'h0, 7'd0));
        directed_rows.push_back(make_row(NO_CFG, pal_pkg::FUNC_INSERT, 6'd2, 32'h5A5A_5A5A,
                                         1'b0, pal_pkg::ST_OK, 32'h0, 7'd0));
        directed_rows.push_back(make_row(NO_CFG, pal_pkg::FUNC_DELETE, 6'd0, 32'h0, 1'b0,
                                         pal_pkg::ST_OK, 32'h0, 7'd0));
        directed_rows.push_back(make_row(NO_CFG, pal_pkg::FUNC_DELETE, 6'd3, 32'h0, 1'b1,
                                         pal_pkg::ST_RANGE, 32'h0, 7'd3));
        directed_rows.push_back(make_row(NO_CFG, pal_pkg::FUNC_CLEAR, 6'd63, 32'hFFFF_FFFF,
                                         1'b1, pal_pkg::ST_OK, 32'h0, 7'd0));
        directed_rows.push_back(make_row(NO_CFG, pal_pkg::FUNC_GET, 6'd0, 32'h0, 1'b1,
                                         pal_pkg::ST_RANGE, 32'h0, 7'd0));
        directed_rows.push_back(make_row(1, pal_pkg::FUNC_INSERT, 6'd0, 32'h1234_5678, 1'b1,
                                         pal_pkg::ST_OK, 32'h0, 7'd1));
        directed_rows.push_back(make_row(NO_CFG, pal_pkg::FUNC_INSERT, 6'd0, 32'h1, 1'b1,
                                         pal_pkg::ST_FULL, 32'h0, 7'd1));
        directed_rows.push_back(make_row(0, pal_pkg::FUNC_INSERT, 6'd0, 32'h2, 1'b1,
                                         pal_pkg::ST_FULL, 32'h0, 7'd1));
        directed_rows.push_back(make_row(NO_CFG, pal_pkg::FUNC_GET, 6'd0, 32'h0, 1'b1,
                                         pal_pkg::ST_OK, 32'h1234_5678, 7'd1));
        directed_rows.push_back(make_row(127, pal_pkg::FUNC_INSERT, 6'd5, 32'h3, 1'b1,
                                         pal_pkg::ST_OK, 32'h0, 7'd2));
        directed_rows.push_back(make_row(NO_CFG, pal_pkg::FUNC_DELETE, 6'd0, 32'h0, 1'b1,
                                         pal_pkg::ST_OK, 32'h1234_5678, 7'd1));
        directed_rows.push_back(make_row(NO_CFG, pal_pkg::FUNC_GET, 6'd0, 32'h0, 1'b1,
                                         pal_pkg::ST_OK, 32'h3, 7'd1));
        directed_rows.push_back(make_row(NO_CFG, pal_pkg::FUNC_CLEAR, 6'd0, 32'h0, 1'b1,
                                         pal_pkg::ST_OK, 32'h0, 7'd0));

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.cfg_value != NO_CFG)
                write_capacity(7'(row.cfg_value));
            send_request(row.op, row.p, row.w, row.typed, row.want);
        end

        // Fill the whole store, hit the full list, then shrink capacity under the count
        write_capacity(7'd64);
        for (int i = 0; i < LIST_DEPTH; i++)
            send_request(pal_pkg::FUNC_INSERT, 6'($urandom_range(0, 63)), $urandom,
                         1'b0, blank);
        send_request(pal_pkg::FUNC_INSERT, 6'd0, $urandom, 1'b0, blank);
        send_request(pal_pkg::FUNC_GET, 6'd63, 32'h0, 1'b0, blank);
        send_request(pal_pkg::FUNC_DELETE, 6'd63, 32'h0, 1'b0, blank);
        send_request(pal_pkg::FUNC_DELETE, 6'd0, 32'h0, 1'b0, blank);
        write_capacity(7'd10);
        send_request(pal_pkg::FUNC_INSERT, 6'd20, $urandom, 1'b0, blank);
        run_random_phase(40, MIX_SHRINK);

        for (int ph = 0; ph < 12; ph++)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                write_capacity(7'd64);
            else if (pick == 1)
                write_capacity(7'd1);
            else if (pick == 2)
                write_capacity(7'($urandom_range(65, 127)));
            else
                write_capacity(7'($urandom_range(1, 64)));
            calm = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 2);
            mix = (pick == 0) ? MIX_GROW : (pick == 1) ? MIX_SHRINK : MIX_EVEN;
            run_random_phase(95, mix);
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("Sent %0d requests, checked %0d results, %0d capacity writes",
                 n_sent, n_results, n_cfg);
        $display("Saw %0d full-list refusals and %0d out-of-range accesses", n_full, n_range);
        if (n_errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
